// ===== hw/rtl/gaussian_blur_5x5_rgb_top_defines.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef GAUSSIAN_BLUR_5X5_RGB_TOP_DEFINES_SVH
`define GAUSSIAN_BLUR_5X5_RGB_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define GB5_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GB5_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GB5_ASSERT(label, prop, msg)
`define GB5_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hw/rtl/gb5_pkg.sv =====
package gb5_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int RowSlots  = 6;
	localparam int ColBanks  = 5;
	localparam int BankDepth = (MaxWidth + ColBanks - 1) / ColBanks;
	localparam int BankAw    = $clog2(BankDepth);
	localparam int ColW      = $clog2(MaxWidth);
	localparam int RowW      = 11;
	localparam int CfgW      = 11;
	localparam int SlotW     = 3;
	localparam int BankW     = 3;
	localparam int DiffW     = 12;
	localparam int SumW      = 17;
	localparam int RowSumW   = 15;
	localparam int RecipW    = 24;
	localparam int RecipShift = 32;
	localparam logic [RecipW-1:0] RecipMul = 24'd15732481;

	localparam logic [1:0] CfgImageWidth  = 2'd0;
	localparam logic [1:0] CfgImageHeight = 2'd1;

	typedef logic [23:0] pix_t;
	typedef logic [7:0] chan_t;

	typedef struct packed {
		logic                  wr_en;
		logic [SlotW-1:0]      wr_slot;
		logic [BankW-1:0]      wr_bank;
		logic [BankAw-1:0]     wr_addr;
		logic [ColBanks-1:0][BankAw-1:0] rd_addr;
	} lb_ctl_t;

	function automatic logic [6:0] kweight(input int dy, input int dx);
		logic [6:0] w1d [5];
		w1d[0] = 7'd1;
		w1d[1] = 7'd4;
		w1d[2] = 7'd7;
		w1d[3] = 7'd4;
		w1d[4] = 7'd1;
		if (dy == 2 && dx == 2) begin
			return 7'd41;
		end else if ((dy == 2 && (dx == 1 || dx == 3)) || (dx == 2 && (dy == 1 || dy == 3))) begin
			return 7'd26;
		end else if ((dy == 1 || dy == 3) && (dx == 1 || dx == 3)) begin
			return 7'd16;
		end else if (dy == 0 || dy == 4) begin
			return w1d[dx];
		end else begin
			return w1d[dy];
		end
	endfunction

endpackage

// ===== hw/rtl/gb5_linebuf.sv =====
module gb5_linebuf (
	input  logic              clk,
	input  logic              en,
	input  gb5_pkg::lb_ctl_t  ctl,
	input  gb5_pkg::pix_t     wdata,
	output gb5_pkg::pix_t     rdata [gb5_pkg::RowSlots][gb5_pkg::ColBanks]
);
	import gb5_pkg::*;

	// Six row slots, each split into five banks by column modulo five, so the
	// five columns of a window row always fall into five different banks.
	for (genvar s = 0; s < RowSlots; s++) begin : g_slot
		for (genvar b = 0; b < ColBanks; b++) begin : g_bank
			pix_t mem [BankDepth];
			pix_t rd_s1;
			pix_t wd_s1;
			logic hit_s1;
			logic sel_w;

			assign sel_w = ctl.wr_en && (ctl.wr_slot == SlotW'(s)) && (ctl.wr_bank == BankW'(b));

			always_ff @(posedge clk) begin
				if (sel_w) begin
					mem[ctl.wr_addr] <= wdata;
				end
				if (en) begin
					rd_s1  <= mem[ctl.rd_addr[b]];
					wd_s1  <= wdata;
					hit_s1 <= sel_w && (ctl.wr_addr == ctl.rd_addr[b]);
				end
			end

			assign rdata[s][b] = hit_s1 ? wd_s1 : rd_s1;
		end
	end

endmodule

// ===== hw/rtl/gb5_lane.sv =====
module gb5_lane (
	input  logic           clk,
	input  logic           en,
	input  gb5_pkg::chan_t win [5][5],
	output gb5_pkg::chan_t result
);
	import gb5_pkg::*;

	logic [RowSumW-1:0]           row_s2 [5];
	logic [SumW-1:0]              tot_s3;
	logic [SumW+RecipW-1:0]       prod_s4;
	logic [RowSumW-1:0]           row_c [5];

	always_comb begin
		for (int j = 0; j < 5; j++) begin
			row_c[j] = '0;
			for (int i = 0; i < 5; i++) begin
				row_c[j] = row_c[j] + RowSumW'(win[j][i]) * RowSumW'(kweight(j, i));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2  <= row_c;
			tot_s3  <= SumW'(row_s2[0]) + SumW'(row_s2[1]) + SumW'(row_s2[2])
				+ SumW'(row_s2[3]) + SumW'(row_s2[4]);
			prod_s4 <= (SumW+RecipW)'(tot_s3) * (SumW+RecipW)'(RecipMul);
		end
	end

	// Division by 273 as a multiply by the rounded-up reciprocal.
	assign result = prod_s4[RecipShift +: 8];

endmodule

// ===== hw/rtl/gaussian_blur_5x5_rgb_top.sv =====
// 5x5 Gaussian blur (kernel sum 273) of an RGB pixel stream in raster order.
// One item is taken every clock unless the pipeline stalls; a pixel item produces
// the blurred pixel two rows and two columns behind it, and flush items emit the
// rest of the frame once all pixels are in. A result is registered in the line
// store, in the lanes and at the output, and a result held at the output stalls
// the whole pipeline and the input. The rate is set by the line store: thirty banks
// (six row slots by five column phases) each take one write and deliver one read
// per clock, and the three color lanes add and divide in three stages ahead of the
// output register. Writing the width or height register restarts the frame.
`include "gaussian_blur_5x5_rgb_top_defines.svh"

module gaussian_blur_5x5_rgb_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	import gb5_pkg::*;

	logic [CfgW-1:0]   width_q, height_q;
	logic [ColW-1:0]   in_col_q, out_col_q;
	logic [RowW-1:0]   in_row_q, out_row_q;
	logic [BankAw-1:0] in_q_q, out_q_q;
	logic [BankW-1:0]  in_rem_q, out_rem_q;
	logic [SlotW-1:0]  in_slot_q, out_slot_q;
	logic [DiffW-1:0]  diff_q;

	logic en, accept, cfg_wr, pix_ok, wr_en, emit_pix, emit_fl, emit;
	logic in_col_wrap, out_col_wrap, frame_done;
	logic [DiffW-1:0] diff_inc;
	logic [CfgW-1:0] cfg_clamped;
	logic [CfgW-1:0] cfg_limit;
	lb_ctl_t ctl;
	pix_t rdata [RowSlots][ColBanks];

	logic v_s1, v_s2, v_s3, v_s4, fe_s1, fe_s2, fe_s3, fe_s4;
	logic [BankW-1:0] bsel_c [5], bsel_s1 [5];
	logic [SlotW-1:0] rsel_c [5], rsel_s1 [5];
	logic [4:0] cmask_c, cmask_s1, rmask_c, rmask_s1;
	chan_t win_r [5][5], win_g [5][5], win_b [5][5];
	chan_t res_r, res_g, res_b;
	logic out_valid_q, frame_end_q;
	chan_t out_red_q, out_green_q, out_blue_q;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;
	assign accept   = in_valid && en;
	assign cfg_ready = 1'b1;
	assign cfg_wr   = cfg_valid && cfg_ready
		&& (cfg_index == CfgImageWidth || cfg_index == CfgImageHeight);

	assign cfg_limit = (cfg_index == CfgImageHeight) ? CfgW'(MaxHeight) : CfgW'(MaxWidth);

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = CfgW'(1);
		end else if (cfg_data > cfg_limit) begin
			cfg_clamped = cfg_limit;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	assign pix_ok   = in_row_q < height_q;
	assign diff_inc = diff_q + DiffW'(1);
	assign wr_en    = accept && !action && pix_ok;
	assign emit_pix = wr_en && (diff_inc >= ({1'b0, width_q} << 1) + DiffW'(3));
	assign emit_fl  = accept && action && !pix_ok;
	assign emit     = emit_pix || emit_fl;

	assign in_col_wrap  = (CfgW'(in_col_q) + CfgW'(1)) >= width_q;
	assign out_col_wrap = (CfgW'(out_col_q) + CfgW'(1)) >= width_q;
	assign frame_done   = emit && out_col_wrap && ((out_row_q + RowW'(1)) >= height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= CfgW'(1);
			height_q   <= CfgW'(1);
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_q_q     <= '0;
			in_rem_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_q_q    <= '0;
			out_rem_q  <= '0;
			out_slot_q <= '0;
			diff_q     <= '0;
		end else if (cfg_wr || frame_done) begin
			if (cfg_wr && cfg_index == CfgImageWidth) begin
				width_q <= cfg_clamped;
			end
			if (cfg_wr && cfg_index == CfgImageHeight) begin
				height_q <= cfg_clamped;
			end
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_q_q     <= '0;
			in_rem_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_q_q    <= '0;
			out_rem_q  <= '0;
			out_slot_q <= '0;
			diff_q     <= '0;
		end else begin
			if (wr_en) begin
				if (in_col_wrap) begin
					in_col_q  <= '0;
					in_q_q    <= '0;
					in_rem_q  <= '0;
					in_row_q  <= in_row_q + RowW'(1);
					in_slot_q <= (in_slot_q == SlotW'(RowSlots - 1)) ? '0
						: in_slot_q + SlotW'(1);
				end else begin
					in_col_q <= in_col_q + ColW'(1);
					if (in_rem_q == BankW'(ColBanks - 1)) begin
						in_rem_q <= '0;
						in_q_q   <= in_q_q + BankAw'(1);
					end else begin
						in_rem_q <= in_rem_q + BankW'(1);
					end
				end
				if (!emit_pix) begin
					diff_q <= diff_inc;
				end
			end
			if (emit) begin
				if (out_col_wrap) begin
					out_col_q  <= '0;
					out_q_q    <= '0;
					out_rem_q  <= '0;
					out_row_q  <= out_row_q + RowW'(1);
					out_slot_q <= (out_slot_q == SlotW'(RowSlots - 1)) ? '0
						: out_slot_q + SlotW'(1);
				end else begin
					out_col_q <= out_col_q + ColW'(1);
					if (out_rem_q == BankW'(ColBanks - 1)) begin
						out_rem_q <= '0;
						out_q_q   <= out_q_q + BankAw'(1);
					end else begin
						out_rem_q <= out_rem_q + BankW'(1);
					end
				end
			end
		end
	end

	// Read addresses per bank, and bank, slot and in-frame flags per window
	// column and row, all for the pixel about to be emitted.
	for (genvar b = 0; b < ColBanks; b++) begin : g_addr
		logic signed [4:0] t, dx, sum;
		assign t   = $signed(5'(b)) - $signed({2'b0, out_rem_q});
		assign dx  = (t > 5'sd2) ? t - 5'sd5 : ((t < -5'sd2) ? t + 5'sd5 : t);
		assign sum = $signed({2'b0, out_rem_q}) + dx;
		assign ctl.rd_addr[b] = (sum < 5'sd0) ? out_q_q - BankAw'(1)
			: ((sum > 5'sd4) ? out_q_q + BankAw'(1) : out_q_q);
	end

	for (genvar i = 0; i < 5; i++) begin : g_win
		logic signed [4:0]  bv, sv;
		logic signed [12:0] cc, rr;
		assign bv = $signed({2'b0, out_rem_q}) + $signed(5'(i - 2));
		assign bsel_c[i] = BankW'((bv < 5'sd0) ? bv + 5'sd5 : ((bv > 5'sd4) ? bv - 5'sd5 : bv));
		assign sv = $signed({2'b0, out_slot_q}) + $signed(5'(i - 2));
		assign rsel_c[i] = SlotW'((sv < 5'sd0) ? sv + 5'sd6 : ((sv > 5'sd5) ? sv - 5'sd6 : sv));
		assign cc = $signed({3'b0, out_col_q}) + $signed(13'(i - 2));
		assign rr = $signed({2'b0, out_row_q}) + $signed(13'(i - 2));
		assign cmask_c[i] = (cc >= 13'sd0) && (cc < $signed({2'b0, width_q}));
		assign rmask_c[i] = (rr >= 13'sd0) && (rr < $signed({2'b0, height_q}));
	end

	assign ctl.wr_en   = wr_en;
	assign ctl.wr_slot = in_slot_q;
	assign ctl.wr_bank = in_rem_q;
	assign ctl.wr_addr = in_q_q;

	gb5_linebuf u_linebuf (
		.clk   (clk),
		.en    (en),
		.ctl   (ctl),
		.wdata ({in_red, in_green, in_blue}),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			bsel_s1  <= bsel_c;
			rsel_s1  <= rsel_c;
			cmask_s1 <= cmask_c;
			rmask_s1 <= rmask_c;
			fe_s1    <= frame_done;
			fe_s2    <= fe_s1;
			fe_s3    <= fe_s2;
			fe_s4    <= fe_s3;
		end
	end

	always_comb begin
		for (int j = 0; j < 5; j++) begin
			for (int i = 0; i < 5; i++) begin
				if (rmask_s1[j] && cmask_s1[i]) begin
					win_r[j][i] = rdata[rsel_s1[j]][bsel_s1[i]][23:16];
					win_g[j][i] = rdata[rsel_s1[j]][bsel_s1[i]][15:8];
					win_b[j][i] = rdata[rsel_s1[j]][bsel_s1[i]][7:0];
				end else begin
					win_r[j][i] = '0;
					win_g[j][i] = '0;
					win_b[j][i] = '0;
				end
			end
		end
	end

	gb5_lane u_lane_r (.clk(clk), .en(en), .win(win_r), .result(res_r));
	gb5_lane u_lane_g (.clk(clk), .en(en), .win(win_g), .result(res_g));
	gb5_lane u_lane_b (.clk(clk), .en(en), .win(win_b), .result(res_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= emit;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_red_q   <= res_r;
			out_green_q <= res_g;
			out_blue_q  <= res_b;
			frame_end_q <= fe_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;
	assign frame_end = frame_end_q;

	`GB5_ASSERT(a_stall_only_when_blocked, in_stall |-> out_valid_q, "input stalled without a waiting result")
	`GB5_ASSERT(a_diff_bound, diff_q <= ({1'b0, width_q} << 1) + DiffW'(2), "pending pixel count exceeds two rows")
	`GB5_ASSERT(a_frame_restart, (frame_done && !cfg_wr) |=> (in_row_q == '0 && out_row_q == '0 && diff_q == '0), "frame end did not restart counters")
	`GB5_ASSERT(a_flush_after_input, emit_fl |-> (in_row_q >= height_q), "flush emitted before the frame was complete")

endmodule

// ===== tb/gaussian_blur_5x5_rgb_top_test.sv =====
`timescale 1ns / 100ps

module gaussian_blur_5x5_rgb_top_test;
	import gb5_pkg::*;

	localparam logic [1:0] CfgSpare2 = 2'd2;
	localparam logic [1:0] CfgSpare3 = 2'd3;
	localparam bit ActPixel = 1'b0;
	localparam bit ActFlush = 1'b1;
	localparam int DrainCycles = 12;
	localparam int StuckLimit = 5000;
	localparam int KernelTap [25] = '{1, 4, 7, 4, 1, 4, 16, 26, 16, 4, 7, 26, 41, 26, 7,
		4, 16, 26, 16, 4, 1, 4, 7, 4, 1};

	typedef struct {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  last;
	} blurred_pix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = 1'b0;
	logic [7:0]  in_red = '0;
	logic [7:0]  in_green = '0;
	logic [7:0]  in_blue = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic        frame_end;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;

	gaussian_blur_5x5_rgb_top dut (.*);

	always #2ns clk = ~clk;

	// Predicted state of the block.
	int unsigned frame_w, frame_h;
	int unsigned pix_col, pix_row, emit_col, emit_row;
	pix_t        line_mem [RowSlots * MaxWidth];
	blurred_pix_t blurred_q [$];

	int fail_count = 0;
	int items_sent = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_off_cycles = 0;
	int quiet_cycles = 0;

	function automatic int unsigned clamp_size(logic [10:0] value, int unsigned limit);
		int unsigned v;
		v = value;
		if (v == 0) v = 1;
		if (v > limit) v = limit;
		return v;
	endfunction

	function automatic void restart_counters();
		pix_col = 0;
		pix_row = 0;
		emit_col = 0;
		emit_row = 0;
	endfunction

	function automatic void predict_cfg(logic [1:0] idx, logic [10:0] data);
		if (idx == CfgImageWidth) begin
			frame_w = clamp_size(data, MaxWidth);
			restart_counters();
		end else if (idx == CfgImageHeight) begin
			frame_h = clamp_size(data, MaxHeight);
			restart_counters();
		end
	endfunction

	function automatic void emit_blurred();
		blurred_pix_t res;
		int rr, cc, k;
		int unsigned sr, sg, sb;
		pix_t p;
		sr = 0;
		sg = 0;
		sb = 0;
		k = 0;
		for (int dy = -2; dy <= 2; dy++) begin
			for (int dx = -2; dx <= 2; dx++) begin
				rr = int'(emit_row) + dy;
				cc = int'(emit_col) + dx;
				if (rr >= 0 && cc >= 0 && rr < int'(frame_h) && cc < int'(frame_w)) begin
					p = line_mem[(rr % RowSlots) * MaxWidth + cc];
					sr += KernelTap[k] * p[23:16];
					sg += KernelTap[k] * p[15:8];
					sb += KernelTap[k] * p[7:0];
				end
				k++;
			end
		end
		res.red = chan_t'(sr / 273);
		res.green = chan_t'(sg / 273);
		res.blue = chan_t'(sb / 273);
		res.last = 1'b0;
		emit_col++;
		if (emit_col >= frame_w) begin
			emit_col = 0;
			emit_row++;
			if (emit_row >= frame_h) begin
				res.last = 1'b1;
				restart_counters();
			end
		end
		blurred_q.push_back(res);
	endfunction

	function automatic void predict_item(bit act, chan_t r, chan_t g, chan_t b);
		int unsigned received, emitted;
		received = pix_row * frame_w + pix_col;
		emitted = emit_row * frame_w + emit_col;
		if (act == ActPixel) begin
			if (pix_row >= frame_h) return;
			line_mem[(pix_row % RowSlots) * MaxWidth + pix_col] = {r, g, b};
			pix_col++;
			if (pix_col >= frame_w) begin
				pix_col = 0;
				pix_row++;
			end
			if (received + 1 - emitted >= 2 * frame_w + 3) emit_blurred();
		end else if (received >= frame_w * frame_h && emitted < frame_w * frame_h) begin
			emit_blurred();
		end
	endfunction

	// Receiver: random stalls, optional long hold-off, and the result check.
	always @(posedge clk) begin
		blurred_pix_t exp_pix;
		if (arst_n && out_valid && !out_stall) begin
			if (blurred_q.size() == 0) begin
				$error("unexpected result red=%0d green=%0d blue=%0d", out_red, out_green,
					out_blue);
				fail_count++;
			end else begin
				exp_pix = blurred_q.pop_front();
				if (out_red !== exp_pix.red) begin
					$error("out_red expected %0d actual %0d", exp_pix.red, out_red);
					fail_count++;
				end
				if (out_green !== exp_pix.green) begin
					$error("out_green expected %0d actual %0d", exp_pix.green, out_green);
					fail_count++;
				end
				if (out_blue !== exp_pix.blue) begin
					$error("out_blue expected %0d actual %0d", exp_pix.blue, out_blue);
					fail_count++;
				end
				if (frame_end !== exp_pix.last) begin
					$error("frame_end expected %0d actual %0d", exp_pix.last, frame_end);
					fail_count++;
				end
			end
		end
		if (hold_off_cycles > 0) begin
			out_stall <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Watchdog on cycles in which no channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StuckLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(bit act, chan_t r, chan_t g, chan_t b);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		in_red <= r;
		in_green <= g;
		in_blue <= b;
		do @(posedge clk); while (in_stall);
		predict_item(act, r, g, b);
		items_sent++;
	endtask

	task automatic send_pixel(chan_t r, chan_t g, chan_t b);
		send_item(ActPixel, r, g, b);
	endtask

	task automatic send_flush();
		send_item(ActFlush, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
	endtask

	// Lets the pipeline run dry so that a register may be written.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (blurred_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [10:0] data);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		predict_cfg(idx, data);
		@(posedge clk);
	endtask

	task automatic set_frame(logic [10:0] w, logic [10:0] h);
		write_cfg(CfgImageWidth, w);
		write_cfg(CfgImageHeight, h);
	endtask

	task automatic flush_frame();
		while (pix_row != 0 || pix_col != 0) send_flush();
	endtask

	// One frame of random pixels. Noise adds early flushes and a stray pixel
	// after the last one; a broken frame is abandoned partway.
	task automatic random_frame(bit noisy, bit broken);
		int unsigned n, cut;
		n = frame_w * frame_h;
		cut = broken ? $urandom_range(n - 1) : n;
		for (int unsigned i = 0; i < cut; i++) begin
			if ($urandom_range(15) == 0)
				send_pixel(8'hff, 8'hff, 8'hff);
			else
				send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
			if (noisy && $urandom_range(7) == 0) send_flush();
		end
		if (broken) return;
		if (noisy) send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
		flush_frame();
	endtask

	task automatic test_default_frame();
		send_flush();
		send_pixel(8'hff, 8'h00, 8'hff);
		send_pixel(8'h12, 8'h34, 8'h56);
		flush_frame();
		send_pixel(8'h00, 8'hff, 8'h00);
		flush_frame();
	endtask

	task automatic test_register_limits();
		set_frame(11'd0, 11'd0);
		send_pixel(8'hff, 8'hff, 8'hff);
		flush_frame();
		set_frame(11'd5, 11'd5);
		for (int i = 0; i < 25; i++) send_pixel(8'hff, 8'hff, 8'hff);
		flush_frame();
		// Spare indexes change nothing, so the 5x5 frame still applies.
		write_cfg(CfgSpare2, 11'h7ff);
		write_cfg(CfgSpare3, 11'h555);
		for (int i = 0; i < 25; i++) send_pixel(8'h00, 8'h00, 8'h00);
		flush_frame();
	endtask

	// Oversized registers clamp to the largest frame; a one-pixel-wide frame
	// then runs through every row of the tallest one.
	task automatic test_large_frames();
		set_frame(11'h7ff, 11'h7ff);
		write_cfg(CfgImageWidth, 11'd1);
		random_frame(1'b0, 1'b0);
	endtask

	task automatic test_backpressure();
		set_frame(11'd12, 11'd12);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_off_cycles = 300;
		random_frame(1'b0, 1'b0);
	endtask

	task automatic test_random_frames();
		int target;
		for (int ph = 0; ph < 3; ph++) begin
			snd_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 73 : 0;
			rcv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 23 : 0;
			target = items_sent + 100;
			while (items_sent < target) begin
				set_frame(11'($urandom_range(1, 12)), 11'($urandom_range(1, 12)));
				random_frame($urandom_range(3) == 0, $urandom_range(9) == 0);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		frame_w = 1;
		frame_h = 1;
		restart_counters();
		snd_idle_pct = 23;
		rcv_idle_pct = 73;
		test_default_frame();
		test_register_limits();
		test_large_frames();
		test_backpressure();
		test_random_frames();
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && blurred_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
